FILE: rtl/core/hmdu_pkg.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit package
// Shared widths, operation codes, state codes and small helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package hmdu_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int FUNC_W = 4;
    localparam int CNT_W  = $clog2(DATA_W + 1);

    // Operation codes carried in the func field
    typedef enum logic [FUNC_W-1:0] {
        FN_MFHI   = 4'd0,
        FN_MTHI   = 4'd1,
        FN_MFLO   = 4'd2,
        FN_MTLO   = 4'd3,
        FN_MULT   = 4'd4,
        FN_MULTU  = 4'd5,
        FN_DIV    = 4'd6,
        FN_DIVU   = 4'd7,
        FN_DMULTU = 4'd8,
        FN_DDIV   = 4'd9,
        FN_DDIVU  = 4'd10
    } t_func;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Divider launch controls
    typedef struct packed {
        logic start;
        logic half;     // 32-bit divide: 32 iterations on the low word
    } t_div_ctl;

    function automatic logic [DATA_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] zext32(input logic [HALF_W-1:0] v);
        return {{(DATA_W-HALF_W){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hmdu_req_if.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit request channel
// Valid/ready channel carrying the operation code and both operands.
// ---------------------------------------------------------------------------
`default_nettype none

interface hmdu_req_if;
    logic                         valid;
    logic                         ready;
    logic [hmdu_pkg::FUNC_W-1:0]  func;
    logic [hmdu_pkg::DATA_W-1:0]  operand_s;
    logic [hmdu_pkg::DATA_W-1:0]  operand_t;

    modport source (output valid, output func, output operand_s, output operand_t,
                    input ready);
    modport sink   (input valid, input func, input operand_s, input operand_t,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hmdu_rsp_if.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit response channel
// Valid/ready channel carrying HI and LO after each request.
// ---------------------------------------------------------------------------
`default_nettype none

interface hmdu_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hmdu_pkg::DATA_W-1:0]  hi_value;
    logic [hmdu_pkg::DATA_W-1:0]  lo_value;

    modport source (output valid, output hi_value, output lo_value, input ready);
    modport sink   (input valid, input hi_value, input lo_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hmdu_mul.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit bit-serial multiplier
// Unsigned 64x64 shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module hmdu_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [hmdu_pkg::DATA_W-1:0] i_mcand,
    input  wire logic [hmdu_pkg::DATA_W-1:0] i_mplier,
    output logic                             o_done,
    output logic [hmdu_pkg::DATA_W-1:0]      o_prod_hi,
    output logic [hmdu_pkg::DATA_W-1:0]      o_prod_lo
);
    import hmdu_pkg::*;

    logic [DATA_W-1:0] r_acc_hi;
    logic [DATA_W-1:0] r_acc_lo;    // multiplier bits shift out, product bits in
    logic [DATA_W-1:0] r_mcand;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, r_acc_hi} + (r_acc_lo[0] ? {1'b0, r_mcand} : '0);

    // Control: iteration count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load, then shift the accumulator right one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc_hi <= '0;
            r_acc_lo <= i_mplier;
            r_mcand  <= i_mcand;
        end else if (r_busy) begin
            r_acc_hi <= sum[DATA_W:1];
            r_acc_lo <= {sum[0], r_acc_lo[DATA_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_prod_hi = r_acc_hi;
    assign o_prod_lo = r_acc_lo;

endmodule

`default_nettype wire

FILE: rtl/core/hmdu_div.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit bit-serial divider
// Unsigned restoring divider, one quotient bit per cycle, 64 or 32 steps.
// ---------------------------------------------------------------------------
`default_nettype none

module hmdu_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hmdu_pkg::t_div_ctl          i_ctl,
    input  wire logic [hmdu_pkg::DATA_W-1:0] i_num,
    input  wire logic [hmdu_pkg::DATA_W-1:0] i_den,
    output logic                             o_done,
    output logic [hmdu_pkg::DATA_W-1:0]      o_quo,
    output logic [hmdu_pkg::DATA_W-1:0]      o_rem
);
    import hmdu_pkg::*;

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;   // numerator bits shift out, quotient bits in
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              q_bit;

    // Trial subtract of the denominator from the shifted partial remainder
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign q_bit   = ~diff[DATA_W+1];

    // Control: iteration count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.half ? CNT_W'(HALF_W) : CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: a 32-bit divide preloads the numerator into the upper word
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_ctl.half ? {i_num[HALF_W-1:0], {(DATA_W-HALF_W){1'b0}}} : i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/core/hilo_multiply_divide_unit_top.sv
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit
// Keeps HI and LO and runs MIPS mult/div/move requests on bit-serial units.
//
// Usage:
//   i_req carries func, operand_s and operand_t; a request is taken when
//   valid and ready are both high. Ready is high whenever the sequencer is
//   idle, also while the previous response still waits on o_rsp.
//   o_rsp carries hi_value and lo_value, HI and LO after the request.
//   Requests run one at a time: a new request is taken only once the
//   sequencer is back in idle. Moves and unused codes go straight to the
//   write-back state; mult, multu and dmultu run on the multiplier, and
//   div, divu, ddiv and ddivu on the divider (32 iterations for div, divu).
//   The multiplier retires one multiplier bit and the divider one quotient
//   bit per cycle, over 64 (or 32) iterations.
//   Reset clears HI, LO, the sequencer and the response valid.
//   If the receiver stalls, the response holds and the next request is
//   taken and worked on, but it is not written back until the slot frees.
// ---------------------------------------------------------------------------
`default_nettype none

module hilo_multiply_divide_unit_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hmdu_req_if.sink    i_req,
    hmdu_rsp_if.source  o_rsp
);
    import hmdu_pkg::*;

    t_state            r_state, n_state;
    t_func             r_func;
    t_func             req_func;
    logic              r_neg_q;
    logic              r_neg_r;
    logic [DATA_W-1:0] r_opnd;
    logic [DATA_W-1:0] r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;
    logic              r_out_valid;

    logic              req_fire;
    logic              slot_free;
    logic [HALF_W-1:0] s_lo, t_lo;
    logic [DATA_W-1:0] mcand, mplier;
    logic [DATA_W-1:0] num_raw, den_raw;
    logic [DATA_W-1:0] num_mag, den_mag;
    logic              num_neg, den_neg;
    logic              mul_start;
    t_div_ctl          div_ctl;
    logic              mul_done, div_done;
    logic [DATA_W-1:0] prod_hi, prod_lo;
    logic [DATA_W-1:0] quo_mag, rem_mag;
    logic [DATA_W-1:0] quo, rem;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign req_func    = t_func'(i_req.func);
    assign s_lo        = i_req.operand_s[HALF_W-1:0];
    assign t_lo        = i_req.operand_t[HALF_W-1:0];

    // Decode the request into unit operands and launch controls
    always_comb begin
        mcand     = i_req.operand_s;
        mplier    = i_req.operand_t;
        num_raw   = i_req.operand_s;
        den_raw   = i_req.operand_t;
        num_neg   = 1'b0;
        den_neg   = 1'b0;
        mul_start = 1'b0;
        div_ctl   = '0;
        case (req_func)
            FN_MULT: begin
                mcand     = sext32(s_lo);
                mplier    = sext32(t_lo);
                mul_start = req_fire;
            end
            FN_MULTU: begin
                mcand     = zext32(s_lo);
                mplier    = zext32(t_lo);
                mul_start = req_fire;
            end
            FN_DMULTU: begin
                mul_start = req_fire;
            end
            FN_DIV: begin
                num_raw       = sext32(s_lo);
                den_raw       = sext32(t_lo);
                num_neg       = s_lo[HALF_W-1];
                den_neg       = t_lo[HALF_W-1];
                div_ctl.start = req_fire;
                div_ctl.half  = 1'b1;
            end
            FN_DIVU: begin
                num_raw       = zext32(s_lo);
                den_raw       = zext32(t_lo);
                div_ctl.start = req_fire;
                div_ctl.half  = 1'b1;
            end
            FN_DDIV: begin
                num_neg       = i_req.operand_s[DATA_W-1];
                den_neg       = i_req.operand_t[DATA_W-1];
                div_ctl.start = req_fire;
            end
            FN_DDIVU: begin
                div_ctl.start = req_fire;
            end
            default: begin
            end
        endcase
    end

    // Take magnitudes for the unsigned divider
    assign num_mag = num_neg ? (DATA_W'(0) - num_raw) : num_raw;
    assign den_mag = den_neg ? (DATA_W'(0) - den_raw) : den_raw;

    hmdu_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mcand),
        .i_mplier  (mplier),
        .o_done    (mul_done),
        .o_prod_hi (prod_hi),
        .o_prod_lo (prod_lo)
    );

    hmdu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_quo   (quo_mag),
        .o_rem   (rem_mag)
    );

    // Restore signs: quotient negative when signs differ, remainder follows numerator
    assign quo = r_neg_q ? (DATA_W'(0) - quo_mag) : quo_mag;
    assign rem = r_neg_r ? (DATA_W'(0) - rem_mag) : rem_mag;

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (mul_start) begin
                        n_state = ST_MUL;
                    end else if (div_ctl.start) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Write-back values for HI and LO
    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        case (r_func)
            FN_MTHI: begin
                n_hi = r_opnd;
            end
            FN_MTLO: begin
                n_lo = r_opnd;
            end
            FN_MULT, FN_MULTU: begin
                n_lo = sext32(prod_lo[HALF_W-1:0]);
                n_hi = sext32(prod_lo[DATA_W-1:HALF_W]);
            end
            FN_DMULTU: begin
                n_hi = prod_hi;
                n_lo = prod_lo;
            end
            FN_DIV, FN_DIVU: begin
                n_lo = sext32(quo[HALF_W-1:0]);
                n_hi = sext32(rem[HALF_W-1:0]);
            end
            FN_DDIV, FN_DDIVU: begin
                n_lo = quo;
                n_hi = rem;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, HI/LO state and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hi        <= '0;
            r_lo        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && slot_free) begin
                r_hi        <= n_hi;
                r_lo        <= n_lo;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request code, signs and rs value for write-back
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func  <= req_func;
            r_neg_q <= num_neg ^ den_neg;
            r_neg_r <= num_neg;
            r_opnd  <= i_req.operand_s;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.hi_value = r_hi;
    assign o_rsp.lo_value = r_lo;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HI/LO multiply-divide unit testbench
// Runs a short table of directed requests and then a long random run. A
// predictor keeps its own HI and LO copy, and every response is compared
// with the oldest prediction. Both channels idle at random, and the
// response side holds off for long stretches so that the unit backs up.
// ---------------------------------------------------------------------------

module testbench;

    import hmdu_pkg::*;

    localparam int                RANDOM_REQUESTS = 2000;
    localparam int                HOLD_OFF_CYCLES = 400;
    localparam int                DRAIN_CYCLES    = 80;
    localparam int                MAX_REPORTS     = 10;
    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 4'd11;
    localparam logic [FUNC_W-1:0] FN_LAST_CODE    = 4'd15;
    localparam logic [DATA_W-1:0] ALL_ONES        = 64'hffff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] MIN64           = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] MAX64           = 64'h7fff_ffff_ffff_ffff;

    typedef struct {
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
    } t_hilo_pair;

    // One directed request; the expected pair is used only when known is set
    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] t;
        logic              known;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 25;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{FN_MFHI,   64'hdead_beef_0123_4567, 64'h89ab_cdef_fedc_ba98, 1'b1, 64'h0, 64'h0},
        '{FN_MFLO,   ALL_ONES, ALL_ONES, 1'b1, 64'h0, 64'h0},
        '{FN_MTHI,   ALL_ONES, 64'h0, 1'b1, ALL_ONES, 64'h0},
        '{FN_MTLO,   MIN64, ALL_ONES, 1'b1, ALL_ONES, MIN64},
        '{FN_MFHI,   64'h0, 64'h0, 1'b1, ALL_ONES, MIN64},
        '{FN_MFLO,   64'h0, 64'h0, 1'b1, ALL_ONES, MIN64},
        '{FN_MULT,   64'haaaa_aaaa_7fff_ffff, 64'h5555_5555_7fff_ffff, 1'b0, 64'h0, 64'h0},
        '{FN_MULT,   64'h5555_5555_8000_0000, ALL_ONES ^ 64'h7fff_ffff, 1'b0, 64'h0, 64'h0},
        '{FN_MULT,   ALL_ONES, 64'h1, 1'b0, 64'h0, 64'h0},
        '{FN_MULTU,  64'h0000_0000_ffff_ffff, ALL_ONES, 1'b0, 64'h0, 64'h0},
        '{FN_DIV,    64'h5, 64'h1234_5678_0000_0000, 1'b1, 64'h5, ALL_ONES},
        '{FN_DIV,    64'h1234_5678_8000_0000, 64'h0, 1'b1, 64'hffff_ffff_8000_0000, 64'h1},
        '{FN_DIV,    64'h8000_0000, 64'hffff_ffff, 1'b1, 64'h0, 64'hffff_ffff_8000_0000},
        '{FN_DIV,    64'hffff_fff9, 64'h2, 1'b0, 64'h0, 64'h0},
        '{FN_DIVU,   64'h8000_0000, 64'h0, 1'b1, 64'hffff_ffff_8000_0000, ALL_ONES},
        '{FN_DIVU,   64'hffff_ffff, 64'h3, 1'b0, 64'h0, 64'h0},
        '{FN_DMULTU, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES - 64'h1, 64'h1},
        '{FN_DMULTU, 64'h0, 64'h1357_9bdf_2468_ace0, 1'b0, 64'h0, 64'h0},
        '{FN_DDIV,   MIN64, 64'h0, 1'b1, MIN64, 64'h1},
        '{FN_DDIV,   MAX64, 64'h0, 1'b1, MAX64, ALL_ONES},
        '{FN_DDIV,   MIN64, ALL_ONES, 1'b1, 64'h0, MIN64},
        '{FN_DDIV,   ALL_ONES - 64'h6, 64'h2, 1'b0, 64'h0, 64'h0},
        '{FN_DDIVU,  ALL_ONES, 64'h0, 1'b1, ALL_ONES, ALL_ONES},
        '{FN_DDIVU,  ALL_ONES, 64'h7, 1'b0, 64'h0, 64'h0},
        '{FN_LAST_CODE, 64'h1111_2222_3333_4444, 64'h5, 1'b0, 64'h0, 64'h0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmdu_req_if req_ch ();
    hmdu_rsp_if rsp_ch ();

    hilo_multiply_divide_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predictor state and the pairs still owed by the unit
    logic [DATA_W-1:0] model_hi = '0;
    logic [DATA_W-1:0] model_lo = '0;
    t_hilo_pair        awaited_hilo_q [$];
    int                mismatch_count = 0;

    // Side information for the request currently on the channel
    logic              cur_known = 1'b0;
    logic [DATA_W-1:0] cur_hi    = '0;
    logic [DATA_W-1:0] cur_lo    = '0;

    // Stimulus shaping
    bit calm_stretch      = 1'b0;
    bit hold_off_pending  = 1'b0;

    always #4 i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] sx32(input logic [HALF_W-1:0] w);
        return {{HALF_W{w[HALF_W-1]}}, w};
    endfunction

    // Work out HI and LO after one request
    function automatic void compute_hilo(input logic [FUNC_W-1:0] fn,
                                         input logic [DATA_W-1:0] s,
                                         input logic [DATA_W-1:0] t,
                                         inout logic [DATA_W-1:0] hi,
                                         inout logic [DATA_W-1:0] lo);
        logic [DATA_W-1:0]   p64;
        logic [2*DATA_W-1:0] p128;
        logic [HALF_W-1:0]   n32, d32, nm32, dm32, q32, r32;
        logic [DATA_W-1:0]   nm64, dm64, q64, r64;
        case (fn)
            FN_MTHI: hi = s;
            FN_MTLO: lo = s;
            FN_MULT: begin
                p64 = sx32(s[HALF_W-1:0]) * sx32(t[HALF_W-1:0]);
                lo  = sx32(p64[HALF_W-1:0]);
                hi  = sx32(p64[DATA_W-1:HALF_W]);
            end
            FN_MULTU: begin
                p64 = {32'h0, s[HALF_W-1:0]} * {32'h0, t[HALF_W-1:0]};
                lo  = sx32(p64[HALF_W-1:0]);
                hi  = sx32(p64[DATA_W-1:HALF_W]);
            end
            FN_DIV: begin
                n32 = s[HALF_W-1:0];
                d32 = t[HALF_W-1:0];
                if (d32 == '0) begin
                    lo = n32[HALF_W-1] ? 64'h1 : ALL_ONES;
                    hi = sx32(n32);
                end else begin
                    nm32 = n32[HALF_W-1] ? -n32 : n32;
                    dm32 = d32[HALF_W-1] ? -d32 : d32;
                    q32  = nm32 / dm32;
                    r32  = nm32 % dm32;
                    if (n32[HALF_W-1] != d32[HALF_W-1]) q32 = -q32;
                    if (n32[HALF_W-1]) r32 = -r32;
                    lo = sx32(q32);
                    hi = sx32(r32);
                end
            end
            FN_DIVU: begin
                n32 = s[HALF_W-1:0];
                d32 = t[HALF_W-1:0];
                if (d32 == '0) begin
                    lo = ALL_ONES;
                    hi = sx32(n32);
                end else begin
                    lo = sx32(n32 / d32);
                    hi = sx32(n32 % d32);
                end
            end
            FN_DMULTU: begin
                p128 = {64'h0, s} * {64'h0, t};
                hi   = p128[2*DATA_W-1:DATA_W];
                lo   = p128[DATA_W-1:0];
            end
            FN_DDIV: begin
                if (t == '0) begin
                    lo = s[DATA_W-1] ? 64'h1 : ALL_ONES;
                    hi = s;
                end else begin
                    nm64 = s[DATA_W-1] ? -s : s;
                    dm64 = t[DATA_W-1] ? -t : t;
                    q64  = nm64 / dm64;
                    r64  = nm64 % dm64;
                    if (s[DATA_W-1] != t[DATA_W-1]) q64 = -q64;
                    if (s[DATA_W-1]) r64 = -r64;
                    lo = q64;
                    hi = r64;
                end
            end
            FN_DDIVU: begin
                if (t == '0) begin
                    lo = ALL_ONES;
                    hi = s;
                end else begin
                    lo = s / t;
                    hi = s % t;
                end
            end
            default: ;  // moves from HI/LO and unused codes keep the state
        endcase
    endfunction

    // Operand with a bias toward edge values and small magnitudes
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = 64'h1;
            2:       v = ALL_ONES;
            3:       v = MIN64;
            4:       v = MAX64;
            5:       v = {$urandom, 32'h8000_0000};
            6:       v = {$urandom, 32'hffff_ffff};
            7: begin
                v = DATA_W'($urandom_range(1, 16));
                if ($urandom_range(0, 1)) v = -v;
            end
            8:       v = {32'h0, $urandom};
            9:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] act_v);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
        mismatch_count++;
    endtask

    // Offer one request from the falling edge and hold it until taken
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] s,
                                input logic [DATA_W-1:0] t, input logic known,
                                input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] lo);
        while (!calm_stretch && $urandom_range(0, 99) < 10) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= fn;
        req_ch.operand_s <= s;
        req_ch.operand_t <= t;
        cur_known        <= known;
        cur_hi           <= hi;
        cur_lo           <= lo;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Predict on each taken request, check each taken response
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] nh, nl;
        t_hilo_pair        want;
        if (i_rst_n === 1'b1) begin
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                nh = model_hi;
                nl = model_lo;
                compute_hilo(req_ch.func, req_ch.operand_s, req_ch.operand_t, nh, nl);
                model_hi = nh;
                model_lo = nl;
                want.hi  = cur_known ? cur_hi : nh;
                want.lo  = cur_known ? cur_lo : nl;
                awaited_hilo_q.push_back(want);
            end
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                if (awaited_hilo_q.size() == 0) begin
                    note_mismatch("unexpected response, hi", '0, rsp_ch.hi_value);
                end else begin
                    want = awaited_hilo_q.pop_front();
                    if (rsp_ch.hi_value !== want.hi)
                        note_mismatch("hi_value", want.hi, rsp_ch.hi_value);
                    if (rsp_ch.lo_value !== want.lo)
                        note_mismatch("lo_value", want.lo, rsp_ch.lo_value);
                end
            end
        end
    end

    // Response side: random idling plus long hold-offs on request
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall_left       = HOLD_OFF_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Hard stop
    initial begin
        #(5_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    // Reset, directed table, random run, drain
    initial begin
        logic [FUNC_W-1:0] fn;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FN_MFHI;
        req_ch.operand_s <= '0;
        req_ch.operand_t <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].func, directed_rows[i].s, directed_rows[i].t,
                         directed_rows[i].known, directed_rows[i].hi, directed_rows[i].lo);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // back up the unit twice, once inside the stretch without idling
            if (i == 100 || i == 800) hold_off_pending = 1'b1;
            calm_stretch = (i >= 600 && i < 1000);
            if ($urandom_range(0, 99) < 3)
                fn = FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE));
            else
                fn = FUNC_W'($urandom_range(FN_MFHI, FN_DDIVU));
            send_request(fn, pick_operand(), pick_operand(), 1'b0, '0, '0);
        end
        req_ch.valid <= 1'b0;
        calm_stretch = 1'b0;

        while (awaited_hilo_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_hilo_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
